/* rtl/log_line_field_splitter_core_macros.svh */
// ---------------------------------------------------------------------------
// log line field splitter assertion macros
// shared property wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef LOG_LINE_FIELD_SPLITTER_CORE_MACROS_SVH
`define LOG_LINE_FIELD_SPLITTER_CORE_MACROS_SVH

// property checked only outside reset
`define LFS_ASSERT(lbl, ck, rstn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
        else $error("log line field splitter check failed");

// property checked at every edge, reset included
`define LFS_ASSERT_ALWAYS(lbl, ck, prop) \
    lbl: assert property (@(posedge ck) prop) \
        else $error("log line field splitter check failed during reset");

`endif

/* rtl/lfs_pkg.sv */
// ---------------------------------------------------------------------------
// lfs_pkg
// types and constants shared by the log line field splitter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfs_pkg;

    // input item: one byte of the line
    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_last;
    } in_item_t;

    // result item
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] out_byte;
        logic [4:0] field_index;
        logic       field_end;
        logic       line_end;
    } out_item_t;

    // queue entry: one or two results caused by one input item
    typedef struct packed {
        logic      two;
        out_item_t first;
        out_item_t second;
    } entry_t;

    typedef enum logic [2:0] {
        MODE_SKIP,
        MODE_PLAIN,
        MODE_QUOTE,
        MODE_BRACK,
        MODE_DROP
    } mode_t;

    typedef enum logic [1:0] {
        SEEN_NONE,
        SEEN_DASH,
        SEEN_DATA
    } seen_t;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_LBRACK = 8'h5B;
    localparam logic [7:0] CHAR_RBRACK = 8'h5D;

    localparam int         FC_W         = 6;
    localparam logic [FC_W-1:0] FC_RESET = 6'd7;
    localparam logic       REG_FIELD_COUNT = 1'b0;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

endpackage

/* rtl/lfs_queue.sv */
// ---------------------------------------------------------------------------
// lfs_queue
// short fifo of result entries between the parser and the output stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfs_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lfs_pkg::entry_t push_entry,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output lfs_pkg::entry_t head
);

    lfs_pkg::entry_t                  slot_reg [lfs_pkg::QUEUE_DEPTH];
    logic [lfs_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [lfs_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [lfs_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full    = (count_reg == lfs_pkg::QCNT_W'(lfs_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/lfs_front.sv */
// ---------------------------------------------------------------------------
// lfs_front
// per-byte parser: classifies each byte and builds its result entry
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfs_front
#(
    parameter int MAX_FIELDS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  lfs_pkg::in_item_t          item,
    input  logic [lfs_pkg::FC_W-1:0]   field_count,
    input  logic                       queue_full,
    output logic                       push,
    output lfs_pkg::entry_t            push_entry
);

    localparam int FW = $clog2(MAX_FIELDS + 1);
    localparam int CW = (FW > lfs_pkg::FC_W) ? FW : lfs_pkg::FC_W;

    lfs_pkg::mode_t  mode_reg, mode_next, mode_eff;
    lfs_pkg::seen_t  seen_reg, seen_next, seen_eff;
    logic [FW-1:0]   cf_reg, cf_next;
    logic [CW-1:0]   lim;
    logic [CW-1:0]   cf_ext;
    logic [CW-1:0]   fc_ext;
    logic [CW-1:0]   max_ext;
    logic [7:0]      b;
    logic            last;
    logic [7:0]      term;
    logic            content;
    logic [1:0]      n_res;
    logic            accept;
    logic [4:0]      idx;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;
    assign b          = item.data_byte;
    assign last       = item.line_last;
    assign idx        = 5'(cf_reg);

    // effective field limit
    assign fc_ext  = CW'(field_count);
    assign max_ext = CW'(MAX_FIELDS);
    assign lim     = (fc_ext > max_ext) ? max_ext : fc_ext;
    assign cf_ext  = CW'(cf_reg);

    // parse step
    always_comb
    begin
        mode_eff = mode_reg;
        if (mode_reg == lfs_pkg::MODE_SKIP && cf_ext >= lim)
        begin
            mode_eff = lfs_pkg::MODE_DROP;
        end
        mode_next  = mode_eff;
        seen_next  = seen_reg;
        seen_eff   = seen_reg;
        cf_next    = cf_reg;
        content    = 1'b0;
        n_res      = 2'd0;
        push_entry = '0;
        term       = lfs_pkg::CHAR_SPACE;

        case (mode_eff)
            lfs_pkg::MODE_SKIP:
            begin
                seen_eff  = lfs_pkg::SEEN_NONE;
                seen_next = lfs_pkg::SEEN_NONE;
                if (b == lfs_pkg::CHAR_SPACE || b == lfs_pkg::CHAR_QUOTE
                    || b == lfs_pkg::CHAR_LBRACK)
                begin
                    if (b == lfs_pkg::CHAR_QUOTE)
                    begin
                        mode_next = lfs_pkg::MODE_QUOTE;
                    end
                    else if (b == lfs_pkg::CHAR_LBRACK)
                    begin
                        mode_next = lfs_pkg::MODE_BRACK;
                    end
                    if (last)
                    begin
                        n_res = 2'd1;
                        push_entry.first = '{1'b0, 8'h00, idx, 1'b1, 1'b1};
                    end
                end
                else
                begin
                    mode_next = lfs_pkg::MODE_PLAIN;
                    content   = 1'b1;
                end
            end
            lfs_pkg::MODE_PLAIN, lfs_pkg::MODE_QUOTE, lfs_pkg::MODE_BRACK:
            begin
                if (mode_eff == lfs_pkg::MODE_QUOTE)
                begin
                    term = lfs_pkg::CHAR_QUOTE;
                end
                else if (mode_eff == lfs_pkg::MODE_BRACK)
                begin
                    term = lfs_pkg::CHAR_RBRACK;
                end
                if (b == term)
                begin
                    n_res = 2'd1;
                    push_entry.first = '{1'b0, 8'h00, idx, 1'b1, last};
                    if (!last)
                    begin
                        cf_next   = cf_reg + FW'(1);
                        seen_next = lfs_pkg::SEEN_NONE;
                        mode_next = ((cf_ext + CW'(1)) >= lim) ? lfs_pkg::MODE_DROP
                                                               : lfs_pkg::MODE_SKIP;
                    end
                end
                else
                begin
                    content = 1'b1;
                end
            end
            default:
            begin
                // dropping the rest of the line
                if (last)
                begin
                    n_res = 2'd1;
                    push_entry.first = '{1'b0, 8'h00, 5'd0, 1'b0, 1'b1};
                end
            end
        endcase

        // content byte of the current field
        if (content)
        begin
            if (seen_eff == lfs_pkg::SEEN_NONE && b == lfs_pkg::CHAR_DASH)
            begin
                seen_next = lfs_pkg::SEEN_DASH;
                if (last)
                begin
                    n_res = 2'd1;
                    push_entry.first = '{1'b0, 8'h00, idx, 1'b1, 1'b1};
                end
            end
            else
            begin
                seen_next = lfs_pkg::SEEN_DATA;
                if (seen_eff == lfs_pkg::SEEN_DASH)
                begin
                    n_res = 2'd2;
                    push_entry.two    = 1'b1;
                    push_entry.first  = '{1'b1, lfs_pkg::CHAR_DASH, idx, 1'b0, 1'b0};
                    push_entry.second = '{1'b1, b, idx, last, last};
                end
                else
                begin
                    n_res = 2'd1;
                    push_entry.first = '{1'b1, b, idx, last, last};
                end
            end
        end

        // line end returns to the start state
        if (last)
        begin
            mode_next = lfs_pkg::MODE_SKIP;
            seen_next = lfs_pkg::SEEN_NONE;
            cf_next   = '0;
        end
    end

    assign push = accept && (n_res != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= lfs_pkg::MODE_SKIP;
            seen_reg <= lfs_pkg::SEEN_NONE;
            cf_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            seen_reg <= seen_next;
            cf_reg   <= cf_next;
        end
    end

endmodule

/* rtl/lfs_back.sv */
// ---------------------------------------------------------------------------
// lfs_back
// output stage: sends the one or two results of each queue entry
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfs_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               queue_empty,
    input  lfs_pkg::entry_t    head,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_ready,
    output lfs_pkg::out_item_t res
);

    logic            hold_valid_reg, hold_valid_next;
    logic            phase_reg, phase_next;
    lfs_pkg::entry_t hold_reg;
    logic            fire;
    logic            done;

    assign res_valid = hold_valid_reg;
    assign res       = phase_reg ? hold_reg.second : hold_reg.first;
    assign fire      = res_valid && res_ready;
    assign done      = fire && (phase_reg || !hold_reg.two);
    assign pop       = (!hold_valid_reg || done) && !queue_empty;

    // holding register control
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        phase_next      = phase_reg;
        if (pop)
        begin
            hold_valid_next = 1'b1;
            phase_next      = 1'b0;
        end
        else if (done)
        begin
            hold_valid_next = 1'b0;
            phase_next      = 1'b0;
        end
        else if (fire)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            phase_reg      <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            hold_reg <= head;
        end
    end

endmodule

/* rtl/log_line_field_splitter_core.sv */
// ---------------------------------------------------------------------------
// log_line_field_splitter_core
// splits log lines into fields and streams their content bytes
// ---------------------------------------------------------------------------
// usage:
//   item_valid/item_ready/item take one byte of a line per item, with
//   line_last set on the final byte. res_valid/res_ready/res give result
//   items: content bytes tagged with field index, field end and line end.
//   field_count is written through the apb port at address 0; the user must
//   write it only while idle: the block itself does not enforce this.
// throughput: one input item per cycle while the queue is not full; an item
//   causes zero, one or two results, and the output stage sends one result
//   per cycle while res is taken, so two-result items are paced by it.
// path: with nothing queued, a result is written into the queue and then
//   into the output holding register, which drives res.
// stall: a stalled receiver keeps res steady; the four-entry queue absorbs
//   results and item_ready falls only when it is full.
// reset: the parser returns to skipping leading spaces at field 0, the
//   queue empties, and field_count returns to 7.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module log_line_field_splitter_core
#(
    parameter int MAX_FIELDS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  lfs_pkg::in_item_t  item,
    output logic               res_valid,
    input  logic               res_ready,
    output lfs_pkg::out_item_t res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [lfs_pkg::FC_W-1:0] field_count_reg;
    logic                     cfg_write;
    logic                     queue_full;
    logic                     queue_empty;
    logic                     push;
    logic                     pop;
    lfs_pkg::entry_t          push_entry;
    lfs_pkg::entry_t          head;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == lfs_pkg::REG_FIELD_COUNT)
                       ? {{(32 - lfs_pkg::FC_W){1'b0}}, field_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_count_reg <= lfs_pkg::FC_RESET;
        end
        else if (cfg_write && paddr[2] == lfs_pkg::REG_FIELD_COUNT)
        begin
            field_count_reg <= pwdata[lfs_pkg::FC_W-1:0];
        end
    end

    lfs_front
    #(
        .MAX_FIELDS (MAX_FIELDS)
    )
    u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .field_count (field_count_reg),
        .queue_full  (queue_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    lfs_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .empty      (queue_empty),
        .head       (head)
    );

    lfs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

endmodule

/* rtl/lfs_checker.sv */
// ---------------------------------------------------------------------------
// lfs_checker
// port-level checks of the log line field splitter, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "log_line_field_splitter_core_macros.svh"

module lfs_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               res_valid,
    input logic               res_ready,
    input lfs_pkg::out_item_t res
);

    // a stalled result holds
    `LFS_ASSERT(a_res_hold, clk, rst_n, res_valid && !res_ready |=> res_valid && $stable(res))

    // no result during reset
    `LFS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !res_valid)

    // results without a content byte carry a zero byte
    `LFS_ASSERT(a_zero_byte, clk, rst_n, res_valid && !res.byte_valid |-> res.out_byte == 8'h00)

    // a result that neither carries a byte nor closes a field is a bare line end
    `LFS_ASSERT(a_bare_end, clk, rst_n, res_valid && !res.byte_valid && !res.field_end |-> res.line_end && res.field_index == 5'd0)

endmodule

bind log_line_field_splitter_core lfs_checker u_lfs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the log line field splitter: a byte-level model
// of the field parser predicts every result item, directed and random lines
// are streamed in under varied field counts and back-pressure
// ---------------------------------------------------------------------------

import lfs_pkg::*;

// expected result tracking and byte-level parser model
class field_scoreboard;
    out_item_t       pending_results[$];
    logic [FC_W-1:0] field_count;
    mode_t           mode;
    logic [5:0]      cur_field;
    seen_t           seen;
    int              max_fields;
    int              errors;

    function new(int max_fields_in);
        max_fields  = max_fields_in;
        field_count = FC_RESET;
        errors      = 0;
        restart_line();
    endfunction

    function void restart_line();
        mode      = MODE_SKIP;
        cur_field = '0;
        seen      = SEEN_NONE;
    endfunction

    function void set_field_count(logic [FC_W-1:0] value);
        field_count = value;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    function void push_result(logic valid, logic [7:0] data, logic [5:0] idx,
                              logic fend, logic lend);
        out_item_t r;
        r.byte_valid  = valid;
        r.out_byte    = data;
        r.field_index = idx[4:0];
        r.field_end   = fend;
        r.line_end    = lend;
        pending_results.push_back(r);
    endfunction

    // advance the parser by one accepted byte and queue what it yields
    function void note_byte(in_item_t it);
        logic [7:0] b;
        logic       last;
        logic [7:0] term;
        int         limit;
        b     = it.data_byte;
        last  = it.line_last;
        limit = (int'(field_count) > max_fields) ? max_fields : int'(field_count);

        if (mode == MODE_SKIP && int'(cur_field) >= limit)
            mode = MODE_DROP;

        // rest of line dropped, only the line end is reported
        if (mode == MODE_DROP) begin
            if (last) begin
                push_result(1'b0, 8'h00, 6'd0, 1'b0, 1'b1);
                restart_line();
            end
            return;
        end

        if (mode == MODE_SKIP) begin
            seen = SEEN_NONE;
            if (b == CHAR_SPACE || b == CHAR_QUOTE || b == CHAR_LBRACK) begin
                if (b == CHAR_QUOTE)
                    mode = MODE_QUOTE;
                else if (b == CHAR_LBRACK)
                    mode = MODE_BRACK;
                if (last) begin
                    push_result(1'b0, 8'h00, cur_field, 1'b1, 1'b1);
                    restart_line();
                end
                return;
            end
            mode = MODE_PLAIN;
        end else begin
            if (mode == MODE_PLAIN)
                term = CHAR_SPACE;
            else if (mode == MODE_QUOTE)
                term = CHAR_QUOTE;
            else
                term = CHAR_RBRACK;
            // terminator closes the field
            if (b == term) begin
                push_result(1'b0, 8'h00, cur_field, 1'b1, last);
                if (last) begin
                    restart_line();
                end else begin
                    cur_field = cur_field + 6'd1;
                    seen      = SEEN_NONE;
                    mode      = (int'(cur_field) >= limit) ? MODE_DROP : MODE_SKIP;
                end
                return;
            end
        end

        // leading dash is held until the next byte decides
        if (seen == SEEN_NONE && b == CHAR_DASH) begin
            seen = SEEN_DASH;
            if (last) begin
                push_result(1'b0, 8'h00, cur_field, 1'b1, 1'b1);
                restart_line();
            end
            return;
        end
        if (seen == SEEN_DASH)
            push_result(1'b1, CHAR_DASH, cur_field, 1'b0, 1'b0);
        push_result(1'b1, b, cur_field, last, last);
        seen = SEEN_DATA;
        if (last)
            restart_line();
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 50)
            $display("%0t ns MISMATCH: %s", $time, msg);
    endtask

    // compare one accepted result item with the oldest expectation
    task check_result(out_item_t got);
        out_item_t exp;
        if (pending_results.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
        end
        exp = pending_results.pop_front();
        if (got.byte_valid !== exp.byte_valid)
            report($sformatf("byte_valid got %b exp %b", got.byte_valid, exp.byte_valid));
        if (got.out_byte !== exp.out_byte)
            report($sformatf("out_byte got %h exp %h", got.out_byte, exp.out_byte));
        if (got.field_index !== exp.field_index)
            report($sformatf("field_index got %0d exp %0d",
                             got.field_index, exp.field_index));
        if (got.field_end !== exp.field_end)
            report($sformatf("field_end got %b exp %b", got.field_end, exp.field_end));
        if (got.line_end !== exp.line_end)
            report($sformatf("line_end got %b exp %b", got.line_end, exp.line_end));
    endtask
endclass

module tb_top;

    localparam int         MAX_FIELDS       = 32;
    localparam logic [2:0] FIELD_COUNT_ADDR = 3'(4 * int'(REG_FIELD_COUNT));
    localparam int         SETTLE_CYCLES    = 8;
    localparam int         PHASE_ITEMS      = 125;
    localparam int         HOLD_CYCLES      = 150;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_ready;
    in_item_t    item;
    logic        res_valid;
    logic        res_ready;
    out_item_t   res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    field_scoreboard results_sb = new(MAX_FIELDS);

    int         send_gap_pct;
    int         recv_stall_pct;
    int         hold_request;
    int         hold_left;
    int         items_sent;
    logic [7:0] line_q[$];

    log_line_field_splitter_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // handshake monitor: inputs are noted before results are checked
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (item_valid && item_ready)
                results_sb.note_byte(item);
            if (res_valid && res_ready)
                results_sb.check_result(res);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        res_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                res_ready <= 1'b0;
                hold_left--;
            end else if (hold_request > 0) begin
                hold_left    = hold_request - 1;
                hold_request = 0;
                res_ready   <= 1'b0;
            end else begin
                res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // one item, with random gaps before it; entered and left at a falling edge
    task send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{data_byte: b, line_last: last};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task send_line();
        for (int i = 0; i < line_q.size(); i++)
            send_byte(line_q[i], i == line_q.size() - 1);
    endtask

    // stop sending until every expected result is back and the pipe is empty
    task wait_results_done();
        item_valid <= 1'b0;
        while (results_sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task read_field_count(input logic [FC_W-1:0] exp);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= FIELD_COUNT_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[FC_W-1:0] !== exp)
            results_sb.report($sformatf("field_count read %0d exp %0d", got[FC_W-1:0], exp));
    endtask

    task write_field_count(input logic [FC_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FIELD_COUNT_ADDR;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        results_sb.set_field_count(value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_field_count(value);
    endtask

    function automatic logic [7:0] content_byte(logic [7:0] excl);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == excl);
        return b;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 9))
            0: return CHAR_SPACE;
            1: return CHAR_QUOTE;
            2: return CHAR_LBRACK;
            3: return CHAR_RBRACK;
            4: return CHAR_DASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly well-formed lines with random content, some pure noise
    task make_line();
        int         nf;
        int         len;
        logic [7:0] term;
        logic [7:0] b;
        bit         unterm;
        line_q.delete();
        if ($urandom_range(0, 7) == 0) begin
            len = $urandom_range(1, 24);
            repeat (len) line_q.push_back(noise_byte());
            return;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) line_q.push_back(CHAR_SPACE);
        nf     = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 36) : $urandom_range(1, 8);
        unterm = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < nf; i++) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    // plain field, must not open like a quoted or bracketed one
                    term = CHAR_SPACE;
                    len  = $urandom_range(1, 6);
                    if ($urandom_range(0, 4) == 0) begin
                        b = CHAR_DASH;
                    end else begin
                        do
                            b = content_byte(CHAR_SPACE);
                        while (b == CHAR_QUOTE || b == CHAR_LBRACK);
                    end
                    line_q.push_back(b);
                    repeat (len - 1) line_q.push_back(content_byte(term));
                end
                2, 3: begin
                    term = ($urandom_range(0, 1) == 0) ? CHAR_QUOTE : CHAR_RBRACK;
                    line_q.push_back(term == CHAR_QUOTE ? CHAR_QUOTE : CHAR_LBRACK);
                    len = $urandom_range(0, 6);
                    if (len > 0 && $urandom_range(0, 4) == 0) begin
                        line_q.push_back(CHAR_DASH);
                        len--;
                    end
                    repeat (len) line_q.push_back(content_byte(term));
                end
                4: begin
                    // lone dash as a plain field
                    term = CHAR_SPACE;
                    line_q.push_back(CHAR_DASH);
                end
                default: begin
                    // lone dash wrapped in quotes or brackets
                    term = ($urandom_range(0, 1) == 0) ? CHAR_QUOTE : CHAR_RBRACK;
                    line_q.push_back(term == CHAR_QUOTE ? CHAR_QUOTE : CHAR_LBRACK);
                    line_q.push_back(CHAR_DASH);
                end
            endcase
            if (i == nf - 1 && unterm)
                break;
            line_q.push_back(term);
            repeat ($urandom_range(0, 1)) line_q.push_back(CHAR_SPACE);
        end
        // line ending: trimmed, as built, or one extra trailing space
        if (!unterm) begin
            case ($urandom_range(0, 2))
                0: begin
                    while (line_q.size() > 1 && line_q[line_q.size() - 1] == CHAR_SPACE)
                        void'(line_q.pop_back());
                end
                2: line_q.push_back(CHAR_SPACE);
                default: ;
            endcase
        end
    endtask

    // main sequence
    initial
    begin
        logic [FC_W-1:0] fc_plan[8];
        int              start;
        bit              paused;

        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        hold_request   = 0;
        items_sent     = 0;
        send_gap_pct   = 38;
        recv_stall_pct = 86;
        fc_plan        = '{6'd32, 6'd0, 6'd1, 6'd63, 6'd7, 6'd3, 6'd0, 6'd32};
        fc_plan[6]     = 6'($urandom_range(2, 40));

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        read_field_count(FC_RESET);

        // directed: extreme bytes, every field kind, held dash cases,
        // unterminated field closed by the line end
        line_q = '{CHAR_SPACE, 8'hFF, 8'h00, CHAR_SPACE, CHAR_QUOTE, CHAR_DASH,
                   CHAR_QUOTE, CHAR_LBRACK, CHAR_DASH, 8'h64, CHAR_RBRACK,
                   CHAR_DASH, CHAR_SPACE, CHAR_DASH, 8'h71};
        send_line();
        // bare opening quote as the whole line
        line_q = '{CHAR_QUOTE};
        send_line();
        // trailing space only
        line_q = '{CHAR_SPACE};
        send_line();
        // lone dash at line end
        line_q = '{CHAR_DASH};
        send_line();
        // closing bracket as last byte
        line_q = '{CHAR_LBRACK, 8'h7F, 8'h80, CHAR_RBRACK};
        send_line();
        // too many fields for the count: rest dropped
        line_q = '{8'h61, CHAR_SPACE, 8'h62, CHAR_SPACE, 8'h63, CHAR_SPACE, 8'h64,
                   CHAR_SPACE, 8'h65, CHAR_SPACE, 8'h66, CHAR_SPACE, 8'h67, CHAR_SPACE,
                   8'h68};
        send_line();

        // random phases over several field counts and idle patterns
        for (int p = 0; p < 8; p++) begin
            wait_results_done();
            write_field_count(fc_plan[p]);
            if (p == 3) begin
                send_gap_pct   = 86;
                recv_stall_pct = 38;
            end else if (p == 6) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            if (p == 0)
                hold_request = HOLD_CYCLES;
            start  = items_sent;
            paused = 1'b0;
            while (items_sent - start < PHASE_ITEMS) begin
                make_line();
                send_line();
                if (p == 4 && !paused && items_sent - start > PHASE_ITEMS / 2) begin
                    wait_results_done();
                    paused = 1'b1;
                end
            end
            // leave a line half sent so the next count lands mid line
            if (p == 5) begin
                make_line();
                for (int i = 0; i < line_q.size() / 2; i++)
                    send_byte(line_q[i], 1'b0);
            end
        end

        wait_results_done();
        if (results_sb.pending() != 0)
            results_sb.report($sformatf("%0d results never arrived", results_sb.pending()));
        if (results_sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* log_line_field_splitter_core.f */
+incdir+rtl
rtl/lfs_pkg.sv
rtl/lfs_queue.sv
rtl/lfs_front.sv
rtl/lfs_back.sv
rtl/log_line_field_splitter_core.sv
rtl/lfs_checker.sv
tb/tb_top.sv
